@@ src/argument_string_guard_core_defines.svh @@
// Assertion macros used by the checker file of the argument string guard.
`ifndef ARGUMENT_STRING_GUARD_CORE_DEFINES_SVH
`define ARGUMENT_STRING_GUARD_CORE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and held off during reset.
`define ASG_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and held off during reset.
`define ASG_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/asg_pkg.sv @@
// Types, constants and match helpers of the argument string guard.
package asg_pkg;

    localparam logic [2:0] MODE_TEXT     = 3'd0;
    localparam logic [2:0] MODE_TOKEN    = 3'd1;
    localparam logic [2:0] MODE_RECORD   = 3'd2;
    localparam logic [2:0] MODE_LEG      = 3'd3;
    localparam logic [2:0] MODE_DIALPLAN = 3'd4;
    localparam logic [2:0] MODE_VARNAME  = 3'd5;

    localparam int HIST_LEN = 6;
    localparam int WIN_LEN  = 7;
    localparam int NUM_KW   = 4;
    localparam int NUM_BAD  = 6;
    localparam logic [3:0] COUNT_SAT = 4'd8;

    // Keyword order: aleg, bleg, both, inline.
    localparam int KW_ALEG   = 0;
    localparam int KW_BLEG   = 1;
    localparam int KW_BOTH   = 2;
    localparam int KW_INLINE = 3;

    localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
        '{"a", "l", "e", "g", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"b", "l", "e", "g", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"b", "o", "t", "h", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"i", "n", "l", "i", "n", "e", 8'h00, 8'h00}
    };
    localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd4, 4'd4, 4'd4, 4'd6};

    localparam logic [7:0] BAD_TEXT [NUM_BAD][8] = '{
        '{"e", "x", "e", "c", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"h", "o", "o", "k", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"a", "p", "i", "_", "o", "n", 8'h00, 8'h00},
        '{"n", "o", "l", "o", "c", "a", "l", 8'h00},
        '{"s", "i", "p", "_", "h", 8'h00, 8'h00, 8'h00},
        '{"x", "m", "l", "_", "c", "d", "r", 8'h00}
    };
    localparam logic [3:0] BAD_LEN [NUM_BAD] = '{4'd4, 4'd4, 4'd6, 4'd7, 4'd5, 4'd7};

    // One classified byte as it travels from the front to the back.
    typedef struct packed {
        logic [7:0] folded;
        logic       ctrl;
        logic       space;
        logic       colon;
        logic       dot;
        logic       nonid;
        logic       last;
        logic       empty;
    } t_item;

    // True if a keyword is still alive after the folded byte at position pos.
    function automatic logic kw_ok(input int k, input logic [3:0] pos,
                                   input logic [7:0] f);
        logic ok;
        ok = 1'b0;
        if (pos < KW_LEN[k]) begin
            ok = (f == KW_TEXT[k][pos[2:0]]);
        end
        return ok;
    endfunction

    // True if the window ends with the given forbidden word.
    function automatic logic bad_hit(input int k, input logic [7:0] win [WIN_LEN]);
        logic hit;
        hit = 1'b1;
        for (int j = 0; j < WIN_LEN; j++) begin
            if (j < int'(BAD_LEN[k])) begin
                if (win[WIN_LEN - 1 - j] != BAD_TEXT[k][3'(int'(BAD_LEN[k]) - 1 - j)]) begin
                    hit = 1'b0;
                end
            end
        end
        return hit;
    endfunction

endpackage

@@ src/asg_queue.sv @@
// Small register queue that decouples the classifier from the evaluator.
module asg_queue #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_wr, do_rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_slot[r_rd_ptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_wr) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_rd) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_wr && !do_rd) begin
            n_count = r_count + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_slot[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

@@ src/asg_front.sv @@
// Input stage: takes one byte a cycle while full is low, classifies and folds it, and feeds the queue.
module asg_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  logic [7:0]    i_char_byte,
    input  logic          i_last_char,
    input  logic          i_empty_string,
    output logic          o_q_wr,
    output asg_pkg::t_item o_q_item,
    input  logic          i_q_full
);
    logic           r_valid, n_valid;
    asg_pkg::t_item r_item;
    asg_pkg::t_item cls;
    logic           take;
    logic           is_upper, is_lower, is_digit;

    assign is_upper = (i_char_byte >= "A") && (i_char_byte <= "Z");
    assign is_lower = (i_char_byte >= "a") && (i_char_byte <= "z");
    assign is_digit = (i_char_byte >= "0") && (i_char_byte <= "9");

    always_comb begin
        cls.folded = is_upper ? (i_char_byte + 8'h20) : i_char_byte;
        cls.ctrl   = (i_char_byte < 8'h20) || (i_char_byte == 8'h7f);
        cls.space  = (i_char_byte == 8'h20) ||
                     ((i_char_byte >= 8'h09) && (i_char_byte <= 8'h0d));
        cls.colon  = (i_char_byte == ":");
        cls.dot    = (i_char_byte == ".");
        cls.nonid  = !(is_upper || is_lower || is_digit || (i_char_byte == "_"));
        cls.last   = i_last_char;
        // The empty flag only means something on the final word.
        cls.empty  = i_last_char && i_empty_string;
    end

    assign o_q_wr   = r_valid;
    assign o_q_item = r_item;
    assign full     = r_valid && i_q_full;
    assign take     = push && !full;
    assign n_valid  = take || (r_valid && i_q_full);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= cls;
        end
    end

endmodule

@@ src/asg_back.sv @@
// Evaluator: keeps the per-string flags and history and gives the verdict word.
module asg_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_wdata,
    input  logic           i_q_empty,
    input  asg_pkg::t_item i_q_item,
    output logic           o_q_rd,
    output logic           empty,
    input  logic           pop,
    output logic           o_accepted
);
    logic [2:0] r_mode;

    logic r_ctrl, n_ctrl;
    logic r_space, n_space;
    logic r_prev_colon, n_prev_colon;
    logic r_dcolon, n_dcolon;
    logic r_prev_dot, n_prev_dot;
    logic r_ddot, n_ddot;
    logic r_nonid, n_nonid;
    logic r_exec, n_exec;
    logic [7:0] r_hist [asg_pkg::HIST_LEN];
    logic [7:0] n_hist [asg_pkg::HIST_LEN];
    logic [3:0] r_count, n_count;
    logic [asg_pkg::NUM_KW-1:0] r_alive, n_alive;
    logic [7:0] win [asg_pkg::WIN_LEN];
    logic [asg_pkg::NUM_KW-1:0] kw_match;

    logic r_out_valid, r_out_acc;
    logic take, finish, tok, verdict_full, verdict_empty, verdict;

    assign take   = !i_q_empty && (!i_q_item.last || !r_out_valid || pop);
    assign finish = take && i_q_item.last;
    assign o_q_rd = take;
    assign empty  = !r_out_valid;
    assign o_accepted = r_out_acc;

    always_comb begin
        n_ctrl       = r_ctrl | i_q_item.ctrl;
        n_space      = r_space | i_q_item.space;
        n_dcolon     = r_dcolon | (i_q_item.colon & r_prev_colon);
        n_prev_colon = i_q_item.colon;
        n_ddot       = r_ddot | (i_q_item.dot & r_prev_dot);
        n_prev_dot   = i_q_item.dot;
        n_nonid      = r_nonid | i_q_item.nonid;

        for (int i = 0; i < asg_pkg::HIST_LEN; i++) begin
            win[i] = r_hist[i];
        end
        win[asg_pkg::WIN_LEN-1] = i_q_item.folded;
        n_exec = r_exec;
        for (int k = 0; k < asg_pkg::NUM_BAD; k++) begin
            if (asg_pkg::bad_hit(k, win)) begin
                n_exec = 1'b1;
            end
        end
        for (int i = 0; i < asg_pkg::HIST_LEN; i++) begin
            n_hist[i] = win[i + 1];
        end

        for (int k = 0; k < asg_pkg::NUM_KW; k++) begin
            n_alive[k] = r_alive[k] & asg_pkg::kw_ok(k, r_count, i_q_item.folded);
        end
        n_count = (r_count < asg_pkg::COUNT_SAT) ? r_count + 4'd1 : r_count;

        for (int k = 0; k < asg_pkg::NUM_KW; k++) begin
            kw_match[k] = n_alive[k] && (n_count == asg_pkg::KW_LEN[k]);
        end
    end

    always_comb begin
        tok = !n_ctrl && !n_space && !n_dcolon;
        unique case (r_mode)
            asg_pkg::MODE_TEXT:     verdict_full = !n_ctrl;
            asg_pkg::MODE_TOKEN:    verdict_full = tok;
            asg_pkg::MODE_RECORD:   verdict_full = tok && !n_ddot;
            asg_pkg::MODE_LEG:      verdict_full = kw_match[asg_pkg::KW_ALEG] ||
                                                   kw_match[asg_pkg::KW_BLEG] ||
                                                   kw_match[asg_pkg::KW_BOTH];
            asg_pkg::MODE_DIALPLAN: verdict_full = tok && !kw_match[asg_pkg::KW_INLINE];
            asg_pkg::MODE_VARNAME:  verdict_full = !n_nonid && !n_exec;
            default:                verdict_full = 1'b0;
        endcase
        unique case (r_mode)
            asg_pkg::MODE_TEXT,
            asg_pkg::MODE_LEG,
            asg_pkg::MODE_DIALPLAN: verdict_empty = 1'b1;
            default:                verdict_empty = 1'b0;
        endcase
        verdict = i_q_item.empty ? verdict_empty : verdict_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= asg_pkg::MODE_TEXT;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_acc <= verdict;
        end
    end

    // Every final word, empty or not, leaves the string state cleared.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || finish) begin
            r_ctrl       <= 1'b0;
            r_space      <= 1'b0;
            r_prev_colon <= 1'b0;
            r_dcolon     <= 1'b0;
            r_prev_dot   <= 1'b0;
            r_ddot       <= 1'b0;
            r_nonid      <= 1'b0;
            r_exec       <= 1'b0;
            for (int i = 0; i < asg_pkg::HIST_LEN; i++) begin
                r_hist[i] <= 8'h00;
            end
            r_count      <= 4'd0;
            r_alive      <= '1;
        end else if (take) begin
            r_ctrl       <= n_ctrl;
            r_space      <= n_space;
            r_prev_colon <= n_prev_colon;
            r_dcolon     <= n_dcolon;
            r_prev_dot   <= n_prev_dot;
            r_ddot       <= n_ddot;
            r_nonid      <= n_nonid;
            r_exec       <= n_exec;
            r_hist       <= n_hist;
            r_count      <= n_count;
            r_alive      <= n_alive;
        end
    end

endmodule

@@ src/argument_string_guard_core.sv @@
// Top level of the argument string guard: classifier, queue and evaluator.
//
//   channel   direction  handshake      payload
//   bytes     in         push / full    i_char_byte, i_last_char, i_empty_string
//   verdicts  out        pop / empty    o_accepted
//   config    in         i_cfg_we       i_cfg_wdata (check mode)
//
// One byte word is taken per cycle while full is low. A verdict passes through the
// classifier register, the queue and the verdict register after its final byte is pushed.
// Reset clears the queue, all string state and sets the check mode to text.
// A waiting verdict only stalls the queue at the next final byte; other bytes
// keep flowing, and full rises once the queue and the classifier register fill.
module argument_string_guard_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_char_byte,
    input  logic       i_last_char,
    input  logic       i_empty_string,
    output logic       empty,
    input  logic       pop,
    output logic       o_accepted,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_wdata
);
    localparam int ITEM_W = $bits(asg_pkg::t_item);

    logic           q_wr, q_full, q_rd, q_empty;
    asg_pkg::t_item q_in_item, q_out_item;
    logic [ITEM_W-1:0] q_rdata;

    assign q_out_item = asg_pkg::t_item'(q_rdata);

    asg_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_char_byte    (i_char_byte),
        .i_last_char    (i_last_char),
        .i_empty_string (i_empty_string),
        .o_q_wr         (q_wr),
        .o_q_item       (q_in_item),
        .i_q_full       (q_full)
    );

    asg_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (q_in_item),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    asg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_empty   (q_empty),
        .i_q_item    (q_out_item),
        .o_q_rd      (q_rd),
        .empty       (empty),
        .pop         (pop),
        .o_accepted  (o_accepted)
    );

endmodule

@@ src/asg_checker.sv @@
// Port-level checks of the argument string guard and their binding to the top level.
`include "argument_string_guard_core_defines.svh"

module asg_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic       o_accepted
);

    // Leaving reset, nothing is queued and no verdict is pending.
    `ASG_ASSERT_NOW(a_reset_idle, !$past(i_rst_n), empty && !full, "block not idle after reset")

    // A verdict that is not popped stays and keeps its value.
    `ASG_ASSERT_NEXT(a_held_verdict, !empty && !pop, !empty && $stable(o_accepted), "pending verdict changed")

    // Back-pressure only builds up behind an accepted word.
    `ASG_ASSERT_NOW(a_full_after_push, $rose(full), $past(push), "full rose without a push")

endmodule

bind argument_string_guard_core asg_checker u_asg_checker (.*);
